/* src/hsap_pkg.sv */
package hsap_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned HALF_W     = WORD_W / 2;
    localparam int unsigned PROBE_W    = 3;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned TRI_W      = 5;

    localparam logic [WORD_W-1:0] MIX_MULT    = 64'hff51afd7ed558ccd;
    localparam int unsigned       MIX_SHIFT   = 33;
    localparam logic [WORD_W-1:0] PROBE_COUNT = 64'd8;

    // mix pipeline depth, one divider cell per dividend bit, one output register
    localparam int unsigned MIX_STAGES = 4;
    localparam int unsigned DIV_CELLS  = WORD_W;
    localparam int unsigned TOTAL_LAT  = MIX_STAGES + DIV_CELLS + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLUME_ID_LOW = 2'd0,
        CFG_REGION_START  = 2'd1,
        CFG_REGION_END    = 2'd2
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_GEOMETRY = 2'd1,
        ST_NOSPACE  = 2'd2
    } t_status;

    typedef struct packed {
        logic [WORD_W-1:0]  id_low;
        logic [WORD_W-1:0]  id_high;
        logic [PROBE_W-1:0] probe_number;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0]   slot_address;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    // what one divider cell hands to the next
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] dvd;
    } t_cell_bus;

    // k(k+1)/2
    function automatic logic [TRI_W-1:0] tri_offset(input logic [PROBE_W-1:0] k);
        logic [TRI_W-1:0] t;
        case (k)
            3'd0:    t = 5'd0;
            3'd1:    t = 5'd1;
            3'd2:    t = 5'd3;
            3'd3:    t = 5'd6;
            3'd4:    t = 5'd10;
            3'd5:    t = 5'd15;
            3'd6:    t = 5'd21;
            3'd7:    t = 5'd28;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

endpackage

/* src/hashed_slot_address_probe.sv */
// Channel  | Handshake               | Payload                                  | Dir
// request  | i_start, o_busy         | i_in (id_low, id_high, probe_number)     | in
// result   | o_strobe (one cycle)    | o_result (slot_address, status)          | out
// config   | i_cfg_we, i_cfg_idx     | i_cfg_wdata                              | in
//
// One transaction per clock; o_busy stays low.
// The result passes through 4 mix stages (fold, 32x32 partial products, product sum, probe offset),
// 64 remainder cells and one output register.
// Synchronous active-low reset clears valid bits and config registers (all zero).
// The receiver cannot stall; results are strobed for exactly one cycle.
module hashed_slot_address_probe
    import hsap_pkg::*;
#(
    parameter logic [WORD_W-1:0] NUM_PROBES = PROBE_COUNT
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  t_in_item             i_in,
    output logic                 o_strobe,
    output t_out_item            o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_wdata
);

    logic [WORD_W-1:0] r_volume;
    logic [WORD_W-1:0] r_start;
    logic [WORD_W-1:0] r_end;
    logic [WORD_W-1:0] r_cap;
    logic              r_geom;
    logic              r_nospace;
    logic              r_pow2;

    logic              r_strobe;
    logic [WORD_W-1:0] r_addr;
    logic [STATUS_W-1:0] r_status;

    logic [WORD_W-1:0] n_cap;
    logic [WORD_W-1:0] n_cap_m1;
    logic              w_accept;
    logic              w_mix_valid;
    logic [WORD_W-1:0] w_mix_dvd;
    t_cell_bus         w_bus [DIV_CELLS+1];

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume <= '0;
            r_start  <= '0;
            r_end    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VOLUME_ID_LOW: r_volume <= i_cfg_wdata;
                CFG_REGION_START:  r_start  <= i_cfg_wdata;
                CFG_REGION_END:    r_end    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // region geometry, computed from the config registers and then registered
    always_comb begin
        n_cap    = r_end - r_start;
        n_cap_m1 = n_cap - 64'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= '0;
            r_geom    <= 1'b1;
            r_nospace <= 1'b0;
            r_pow2    <= 1'b0;
        end else begin
            r_cap     <= n_cap;
            r_geom    <= r_end <= r_start;
            r_nospace <= n_cap < NUM_PROBES;
            r_pow2    <= (n_cap & n_cap_m1) == '0;
        end
    end

    hsap_mix u_mix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_accept),
        .i_item     (i_in),
        .i_volume   (r_volume),
        .i_pow2     (r_pow2),
        .o_valid    (w_mix_valid),
        .o_dividend (w_mix_dvd)
    );

    assign w_bus[0] = '{valid: w_mix_valid, rem: '0, dvd: w_mix_dvd};

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
        hsap_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cap   (r_cap),
            .i_bus   (w_bus[g]),
            .o_bus   (w_bus[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_bus[DIV_CELLS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_geom) begin
            r_addr   <= '0;
            r_status <= ST_GEOMETRY;
        end else if (r_nospace) begin
            r_addr   <= '0;
            r_status <= ST_NOSPACE;
        end else begin
            r_addr   <= r_start + w_bus[DIV_CELLS].rem;
            r_status <= ST_OK;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = '{slot_address: r_addr, status: r_status};

`ifndef SYNTHESIS
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##TOTAL_LAT o_strobe)
        else $error("result strobe missing at fixed latency");
    a_addr_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status == ST_OK |->
            o_result.slot_address >= r_start && o_result.slot_address < r_end)
        else $error("slot address outside region");
    a_error_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status != ST_OK |-> o_result.slot_address == '0)
        else $error("nonzero address with error status");
`endif

endmodule

/* src/hsap_mix.sv */
module hsap_mix
    import hsap_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_in_item          i_item,
    input  logic [WORD_W-1:0] i_volume,
    input  logic              i_pow2,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_dividend
);

    // stage A: fold and first xor-shift
    logic              r_a_valid;
    logic [WORD_W-1:0] r_a_h;
    logic [PROBE_W-1:0] r_a_k;
    // stage B: partial products of the low 64 bits
    logic              r_b_valid;
    logic [WORD_W-1:0] r_b_p00;
    logic [HALF_W-1:0] r_b_p01;
    logic [HALF_W-1:0] r_b_p10;
    logic [PROBE_W-1:0] r_b_k;
    // stage C: product and second xor-shift
    logic              r_c_valid;
    logic [WORD_W-1:0] r_c_h;
    logic [PROBE_W-1:0] r_c_k;
    // stage D: key plus probe offset
    logic              r_d_valid;
    logic [WORD_W-1:0] r_d_dvd;

    logic [WORD_W-1:0] n_fold;
    logic [WORD_W-1:0] n_a_h;
    logic [WORD_W-1:0] n_p00;
    logic [WORD_W-1:0] n_p01;
    logic [WORD_W-1:0] n_p10;
    logic [HALF_W-1:0] n_cross;
    logic [WORD_W-1:0] n_prod;
    logic [WORD_W-1:0] n_c_h;
    logic [WORD_W-1:0] n_offset;

    always_comb begin
        n_fold  = i_item.id_low ^ i_item.id_high ^ i_volume;
        n_a_h   = n_fold ^ (n_fold >> MIX_SHIFT);
        n_p00   = r_a_h[HALF_W-1:0]      * MIX_MULT[HALF_W-1:0];
        n_p01   = r_a_h[HALF_W-1:0]      * MIX_MULT[WORD_W-1:HALF_W];
        n_p10   = r_a_h[WORD_W-1:HALF_W] * MIX_MULT[HALF_W-1:0];
        n_cross = r_b_p01 + r_b_p10;
        n_prod  = r_b_p00 + {n_cross, {HALF_W{1'b0}}};
        n_c_h   = n_prod ^ (n_prod >> MIX_SHIFT);
        if (i_pow2) begin
            n_offset = {{(WORD_W-TRI_W){1'b0}}, tri_offset(r_c_k)};
        end else begin
            n_offset = {{(WORD_W-PROBE_W){1'b0}}, r_c_k};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_h   <= n_a_h;
        r_a_k   <= i_item.probe_number;
        r_b_p00 <= n_p00;
        r_b_p01 <= n_p01[HALF_W-1:0];
        r_b_p10 <= n_p10[HALF_W-1:0];
        r_b_k   <= r_a_k;
        r_c_h   <= n_c_h;
        r_c_k   <= r_b_k;
        r_d_dvd <= r_c_h + n_offset;
    end

    assign o_valid    = r_d_valid;
    assign o_dividend = r_d_dvd;

`ifndef SYNTHESIS
    a_mix_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##MIX_STAGES o_valid)
        else $error("mix pipeline lost or delayed a transaction");
`endif

endmodule

/* src/hsap_div_cell.sv */
module hsap_div_cell
    import hsap_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [WORD_W-1:0] i_cap,
    input  t_cell_bus         i_bus,
    output t_cell_bus         o_bus
);

    logic              r_valid;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_dvd;

    logic [WORD_W:0]   n_shifted;
    logic [WORD_W:0]   n_diff;
    logic              n_ge;
    logic [WORD_W-1:0] n_rem;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        n_shifted = {i_bus.rem, i_bus.dvd[WORD_W-1]};
        n_ge      = n_shifted >= {1'b0, i_cap};
        n_diff    = n_shifted - {1'b0, i_cap};
        if (n_ge) begin
            n_rem = n_diff[WORD_W-1:0];
        end else begin
            n_rem = n_shifted[WORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_bus.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= {i_bus.dvd[WORD_W-2:0], 1'b0};
    end

    assign o_bus = '{valid: r_valid, rem: r_rem, dvd: r_dvd};

`ifndef SYNTHESIS
    a_rem_below_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_bus.valid && i_cap != '0 && i_bus.rem < i_cap |=> o_bus.rem < i_cap)
        else $error("partial remainder not below capacity");
    a_cell_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_bus.valid |=> o_bus.valid)
        else $error("divider cell dropped a transaction");
`endif

endmodule
